/* hdl/icl_pkg.sv */
// Shared codes, types and sizes of the gcd, lcm and square root unit.
package icl_pkg;

  localparam int unsigned OpW  = 32;
  localparam int unsigned ValW = 62;

  localparam logic [1:0] CMD_GCD  = 2'd0;
  localparam logic [1:0] CMD_LCM  = 2'd1;
  localparam logic [1:0] CMD_SQRT = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_BIG = 2'd2;

  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE     = 4'd0;
  localparam dp_op_t OP_LOAD     = 4'd1;
  localparam dp_op_t OP_DIV_X    = 4'd2;
  localparam dp_op_t OP_DIV_Y    = 4'd3;
  localparam dp_op_t OP_SET_G    = 4'd4;
  localparam dp_op_t OP_DIV_L    = 4'd5;
  localparam dp_op_t OP_MUL      = 4'd6;
  localparam dp_op_t OP_NSTEP    = 4'd7;
  localparam dp_op_t OP_DIV_N    = 4'd8;
  localparam dp_op_t OP_FIN_ZERO = 4'd9;
  localparam dp_op_t OP_FIN_G    = 4'd10;
  localparam dp_op_t OP_FIN_PROD = 4'd11;
  localparam dp_op_t OP_FIN_ROOT = 4'd12;
  localparam dp_op_t OP_FIN_NEG  = 4'd13;

  typedef struct packed {
    logic [1:0] cmd;
    logic       a_neg;
    logic       a_zero;
    logic       ma_zero;
    logic       mb_zero;
    logic       x_zero;
    logic       y_zero;
    logic       x_gt_y;
    logic       div_done;
    logic       conv;
  } dp_stat_t;

endpackage

/* hdl/icl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module icl_div #(
  parameter int unsigned W = icl_pkg::OpW
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt;
  logic            busy;
  logic [W-1:0]    dv;
  logic [W:0]      shifted;
  logic            fits;

  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(W);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      rem <= fits ? W'(shifted - {1'b0, dv}) : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != CntW'(1)) |=> busy)
    else $error("divider stopped early");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("divider count empty while busy");
endmodule

/* hdl/icl_datapath.sv */
// Operand registers, shared divider, multiplier and result register.
module icl_datapath #(
  parameter int unsigned W = icl_pkg::OpW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  icl_pkg::dp_op_t         op,
  input  logic [1:0]              command,
  input  logic signed [W-1:0]     operand_a,
  input  logic signed [W-1:0]     operand_b,
  output icl_pkg::dp_stat_t       stat,
  output logic [icl_pkg::ValW-1:0] value,
  output logic [1:0]              status
);
  import icl_pkg::*;

  localparam logic [1:0] DST_X = 2'd0;
  localparam logic [1:0] DST_Y = 2'd1;
  localparam logic [1:0] DST_Q = 2'd2;

  logic [1:0]     cmd;
  logic           a_neg;
  logic [W-1:0]   ma, mb, x, y, g, v, d, q;
  logic [2*W-1:0] prod;
  logic [1:0]     dst;
  logic [W:0]     dq_sum;
  logic [W-1:0]   diff;

  logic         div_start, div_done;
  logic [W-1:0] div_n, div_d, div_quo, div_rem;

  assign dq_sum = {1'b0, d} + {1'b0, q};
  assign diff   = (q > d) ? (q - d) : (d - q);

  always_comb begin
    div_start = 1'b0;
    div_n     = x;
    div_d     = y;
    unique case (op)
      OP_DIV_X: begin div_start = 1'b1; div_n = x;  div_d = y; end
      OP_DIV_Y: begin div_start = 1'b1; div_n = y;  div_d = x; end
      OP_DIV_L: begin div_start = 1'b1; div_n = ma; div_d = g; end
      OP_DIV_N: begin div_start = 1'b1; div_n = v;  div_d = d; end
      default: ;
    endcase
  end

  icl_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (dst)
        DST_X:   x <= div_rem;
        DST_Y:   y <= div_rem;
        default: q <= div_quo;
      endcase
    end
    unique case (op)
      OP_LOAD: begin
        cmd   <= command;
        a_neg <= operand_a[W-1];
        ma    <= operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
        mb    <= operand_b[W-1] ? W'(-operand_b) : W'(operand_b);
        x     <= operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
        y     <= operand_b[W-1] ? W'(-operand_b) : W'(operand_b);
        v     <= operand_a;
        d     <= operand_a;
        q     <= operand_a;
      end
      OP_DIV_X:    dst <= DST_X;
      OP_DIV_Y:    dst <= DST_Y;
      OP_DIV_L:    dst <= DST_Q;
      OP_DIV_N:    dst <= DST_Q;
      OP_SET_G:    g <= (x == '0) ? y : x;
      OP_MUL:      prod <= q * mb;
      OP_NSTEP:    d <= dq_sum[W:1];
      OP_FIN_ZERO: begin value <= '0; status <= ST_OK; end
      OP_FIN_G:    begin value <= ValW'(g); status <= ST_OK; end
      OP_FIN_PROD: begin
        value  <= prod[ValW-1:0];
        status <= (prod > (2*W)'(32'h7FFF_FFFF)) ? ST_BIG : ST_OK;
      end
      OP_FIN_ROOT: begin value <= ValW'((q < d) ? q : d); status <= ST_OK; end
      OP_FIN_NEG:  begin value <= '0; status <= ST_NEG; end
      default: ;
    endcase
  end

  always_comb begin
    stat.cmd      = cmd;
    stat.a_neg    = a_neg;
    stat.a_zero   = (v == '0);
    stat.ma_zero  = (ma == '0);
    stat.mb_zero  = (mb == '0);
    stat.x_zero   = (x == '0);
    stat.y_zero   = (y == '0);
    stat.x_gt_y   = (x > y);
    stat.div_done = div_done;
    stat.conv     = (diff <= W'(1));
  end
endmodule

/* hdl/icl_ctrl.sv */
// Sequencer that steps the datapath through each command and owns the handshakes.
module icl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  icl_pkg::dp_stat_t stat,
  output icl_pkg::dp_op_t   op
);
  import icl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_EUC    = 4'd2;
  localparam logic [3:0] S_EWAIT  = 4'd3;
  localparam logic [3:0] S_LDIV   = 4'd4;
  localparam logic [3:0] S_LWAIT  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_NSTEP  = 4'd7;
  localparam logic [3:0] S_NDIV   = 4'd8;
  localparam logic [3:0] S_NWAIT  = 4'd9;
  localparam logic [3:0] S_NCHK   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state, state_next;
  dp_op_t     fin, fin_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    fin_next   = fin;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin op = OP_LOAD; state_next = S_DECIDE; end
      S_DECIDE: begin
        priority if (stat.cmd == CMD_GCD) state_next = S_EUC;
        else if (stat.cmd == CMD_LCM) begin
          if (stat.ma_zero || stat.mb_zero) begin
            fin_next = OP_FIN_ZERO; state_next = S_FIN;
          end else state_next = S_EUC;
        end else if (stat.cmd == CMD_SQRT) begin
          priority if (stat.a_neg) begin fin_next = OP_FIN_NEG; state_next = S_FIN; end
          else if (stat.a_zero) begin fin_next = OP_FIN_ZERO; state_next = S_FIN; end
          else state_next = S_NSTEP;
        end else begin
          fin_next = OP_FIN_ZERO; state_next = S_FIN;
        end
      end
      S_EUC: begin
        if (stat.x_zero || stat.y_zero) begin
          op = OP_SET_G;
          if (stat.cmd == CMD_GCD) begin fin_next = OP_FIN_G; state_next = S_FIN; end
          else state_next = S_LDIV;
        end else begin
          op = stat.x_gt_y ? OP_DIV_X : OP_DIV_Y;
          state_next = S_EWAIT;
        end
      end
      S_EWAIT: if (stat.div_done) state_next = S_EUC;
      S_LDIV:  begin op = OP_DIV_L; state_next = S_LWAIT; end
      S_LWAIT: if (stat.div_done) state_next = S_MUL;
      S_MUL:   begin op = OP_MUL; fin_next = OP_FIN_PROD; state_next = S_FIN; end
      S_NSTEP: begin op = OP_NSTEP; state_next = S_NDIV; end
      S_NDIV:  begin op = OP_DIV_N; state_next = S_NWAIT; end
      S_NWAIT: if (stat.div_done) state_next = S_NCHK;
      S_NCHK: begin
        if (stat.conv) begin fin_next = OP_FIN_ROOT; state_next = S_FIN; end
        else state_next = S_NSTEP;
      end
      S_FIN: if (out_free) begin op = fin; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fin       <= OP_FIN_ZERO;
    end else begin
      state <= state_next;
      fin   <= fin_next;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !out_free |=> out_valid && (state == S_FIN))
    else $error("result register overwritten");
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECIDE)
    else $error("accepted item not decoded");
  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_EWAIT || state == S_LWAIT || state == S_NWAIT))
    else $error("divider finished outside a wait state");
endmodule

/* hdl/integer_gcd_lcm_sqrt_unit.sv */
// Top level of the gcd, lcm and integer square root unit.
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | command, operand_a, operand_b
//  out     | output    | out_valid / out_ready | value, status
// One item is worked at a time; each remainder or quotient is formed on
// the shared one-bit-per-cycle divider, in Euclid steps and Newton steps alike.
// Reset (rst, synchronous) clears out_valid and returns to idle.
// A result waiting on out_ready holds; a new item is still taken meanwhile.
module integer_gcd_lcm_sqrt_unit #(
  parameter int unsigned W = icl_pkg::OpW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic signed [W-1:0]      operand_a,
  input  logic signed [W-1:0]      operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [icl_pkg::ValW-1:0] value,
  output logic [1:0]               status
);
  import icl_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  icl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .op(op)
  );

  icl_datapath #(.W(W)) u_dp (
    .clk(clk), .rst(rst), .op(op), .command(command), .operand_a(operand_a),
    .operand_b(operand_b), .stat(stat), .value(value), .status(status)
  );
endmodule
